// ===== design/orthonormal_basis_from_forward_top_defines.svh =====
// ----------------------------------------------------------------------------
// orthonormal_basis_from_forward_top_defines.svh
// Assertion macros shared by the basis block. Each expects clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ORTHONORMAL_BASIS_FROM_FORWARD_TOP_DEFINES_SVH
`define ORTHONORMAL_BASIS_FROM_FORWARD_TOP_DEFINES_SVH

// same-cycle implication
`define OBF_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("obf assertion failed");

// next-cycle implication
`define OBF_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("obf assertion failed");

`endif

// ===== design/obf_pkg.sv =====
// ----------------------------------------------------------------------------
// obf_pkg
// Shared types and register codes of the orthonormal basis block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package obf_pkg;

  // pipeline control handed to each unit
  typedef struct packed {
    logic en;   // whole pipe advances
    logic vld;  // item entering the unit
  } obf_ctl_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN   = 3'd6;

endpackage
`default_nettype wire

// ===== design/orthonormal_basis_from_forward_top.sv =====
// ----------------------------------------------------------------------------
// orthonormal_basis_from_forward_top
// Builds a normalized left axis and up axis from a forward vector.
// ----------------------------------------------------------------------------
// Takes one forward item per clock and returns one result per item, in order.
// Components default to Q3.20. Each of the two passes is a two-stage cross
// product, a length unit (squares, sum, square root at two bits a stage) and
// three normalizing dividers at two quotient bits a stage, with one selection
// stage between the passes. Both candidate left axes are formed in parallel.
// When the result side stalls, the whole pipe holds and one more item is
// taken into an input holding register. Configuration is to be written only
// while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "orthonormal_basis_from_forward_top_defines.svh"
module orthonormal_basis_from_forward_top
  import obf_pkg::*;
#(
  parameter int COMPONENT_BITS = 24,
  parameter int FRACTION_BITS  = 20
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                cfg_index,
  input  wire logic [((COMPONENT_BITS > FRACTION_BITS + 1) ?
                      COMPONENT_BITS : FRACTION_BITS + 1)-1:0] cfg_data,
  // forward items
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [COMPONENT_BITS-1:0]    in_fwd_x,
  input  wire logic signed [COMPONENT_BITS-1:0]    in_fwd_y,
  input  wire logic signed [COMPONENT_BITS-1:0]    in_fwd_z,
  // basis items
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [COMPONENT_BITS-1:0]         out_left_x,
  output logic signed [COMPONENT_BITS-1:0]         out_left_y,
  output logic signed [COMPONENT_BITS-1:0]         out_left_z,
  output logic signed [COMPONENT_BITS-1:0]         out_up_out_x,
  output logic signed [COMPONENT_BITS-1:0]         out_up_out_y,
  output logic signed [COMPONENT_BITS-1:0]         out_up_out_z,
  output logic                                     out_used_fallback,
  output logic                                     out_up_degenerate
);

  localparam int C     = COMPONENT_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int MIN_W = F + 1;
  localparam int LW    = (C > MIN_W) ? C : MIN_W;
  localparam int MIN_RST = ((1 << F) + 5000) / 10000;   // about 1e-4
  localparam logic signed [C-1:0] ONE = C'(1) << F;

  // configuration registers
  logic signed [C-1:0] up_x_r, up_y_r, up_z_r;
  logic signed [C-1:0] rf_x_r, rf_y_r, rf_z_r;
  logic [MIN_W-1:0]    min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_x_r    <= '0;
      up_y_r    <= '0;
      up_z_r    <= ONE;
      rf_x_r    <= ONE;
      rf_y_r    <= '0;
      rf_z_r    <= '0;
      min_len_r <= MIN_W'(MIN_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UP_X:  up_x_r    <= cfg_data[C-1:0];
        REG_UP_Y:  up_y_r    <= cfg_data[C-1:0];
        REG_UP_Z:  up_z_r    <= cfg_data[C-1:0];
        REG_FWD_X: rf_x_r    <= cfg_data[C-1:0];
        REG_FWD_Y: rf_y_r    <= cfg_data[C-1:0];
        REG_FWD_Z: rf_z_r    <= cfg_data[C-1:0];
        REG_MIN:   min_len_r <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe advance and input holding register
  logic                en;
  logic                skid_vld_r;
  logic signed [C-1:0] skid_x_r, skid_y_r, skid_z_r;
  logic                src_vld;
  logic signed [C-1:0] src_x, src_y, src_z;

  assign en       = !(out_valid && out_stall);
  assign in_stall = skid_vld_r;
  assign src_vld  = skid_vld_r || in_valid;
  assign src_x    = skid_vld_r ? skid_x_r : in_fwd_x;
  assign src_y    = skid_vld_r ? skid_y_r : in_fwd_y;
  assign src_z    = skid_vld_r ? skid_z_r : in_fwd_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (en) begin
      skid_vld_r <= 1'b0;
    end else if (in_valid && !skid_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_valid && !skid_vld_r) begin
      skid_x_r <= in_fwd_x;
      skid_y_r <= in_fwd_y;
      skid_z_r <= in_fwd_z;
    end
  end

  // first pass: both candidate left axes
  obf_ctl_t ctl_src;
  assign ctl_src = '{en: en, vld: src_vld};

  logic                vld_ca, vld_cb;
  logic signed [C-1:0] ca_x, ca_y, ca_z, cb_x, cb_y, cb_z;
  logic [3*C-1:0]      ca_side;
  logic [MIN_W-1:0]    cb_side;

  obf_cross #(.C(C), .F(F), .SW(3*C)) u_cross_up (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_src),
    .a_x(up_x_r), .a_y(up_y_r), .a_z(up_z_r),
    .b_x(src_x), .b_y(src_y), .b_z(src_z),
    .side_in({src_x, src_y, src_z}),
    .out_vld(vld_ca), .o_x(ca_x), .o_y(ca_y), .o_z(ca_z), .side_out(ca_side)
  );

  obf_cross #(.C(C), .F(F), .SW(MIN_W)) u_cross_fb (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_src),
    .a_x(rf_x_r), .a_y(rf_y_r), .a_z(rf_z_r),
    .b_x(src_x), .b_y(src_y), .b_z(src_z),
    .side_in(min_len_r),
    .out_vld(vld_cb), .o_x(cb_x), .o_y(cb_y), .o_z(cb_z), .side_out(cb_side)
  );

  obf_ctl_t            ctl_la, ctl_lb;
  logic                vld_la, vld_lb;
  logic [C-1:0]        len_a, len_b;
  logic signed [C-1:0] la_x, la_y, la_z, lb_x, lb_y, lb_z;
  logic [3*C-1:0]      la_side;
  logic [MIN_W-1:0]    lb_side;

  assign ctl_la = '{en: en, vld: vld_ca};
  assign ctl_lb = '{en: en, vld: vld_cb};

  obf_len #(.C(C), .SW(3*C)) u_len_up (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_la),
    .v_x(ca_x), .v_y(ca_y), .v_z(ca_z), .side_in(ca_side),
    .out_vld(vld_la), .len(len_a), .o_x(la_x), .o_y(la_y), .o_z(la_z),
    .side_out(la_side)
  );

  obf_len #(.C(C), .SW(MIN_W)) u_len_fb (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_lb),
    .v_x(cb_x), .v_y(cb_y), .v_z(cb_z), .side_in(cb_side),
    .out_vld(vld_lb), .len(len_b), .o_x(lb_x), .o_y(lb_y), .o_z(lb_z),
    .side_out(lb_side)
  );

  // select stage: fall back when the up cross product is too short
  logic                fb;
  logic                sel_vld_r;
  logic signed [C-1:0] sel_x_r, sel_y_r, sel_z_r;
  logic [C-1:0]        sel_len_r;
  logic                sel_ok_r;
  logic                sel_fb_r;
  logic [3*C-1:0]      sel_f_r;
  logic [C-1:0]        sel_len;

  assign fb      = LW'(len_a) < LW'(lb_side);
  assign sel_len = fb ? len_b : len_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
    end else if (en) begin
      sel_vld_r <= vld_la && vld_lb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_x_r   <= fb ? lb_x : la_x;
      sel_y_r   <= fb ? lb_y : la_y;
      sel_z_r   <= fb ? lb_z : la_z;
      sel_len_r <= sel_len;
      sel_ok_r  <= (sel_len != '0) && (LW'(sel_len) >= LW'(lb_side));
      sel_fb_r  <= fb;
      sel_f_r   <= la_side;
    end
  end

  obf_ctl_t            ctl_n1;
  logic                vld_n1;
  logic signed [C-1:0] lf_x, lf_y, lf_z;
  logic [3*C:0]        n1_side;

  assign ctl_n1 = '{en: en, vld: sel_vld_r};

  obf_norm #(.C(C), .F(F), .SW(3*C+1)) u_norm_left (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_n1),
    .v_x(sel_x_r), .v_y(sel_y_r), .v_z(sel_z_r),
    .len(sel_len_r), .ok(sel_ok_r), .side_in({sel_f_r, sel_fb_r}),
    .out_vld(vld_n1), .o_x(lf_x), .o_y(lf_y), .o_z(lf_z), .side_out(n1_side)
  );

  // second pass: up = forward x left
  obf_ctl_t            ctl_c2, ctl_l2, ctl_n2;
  logic                vld_c2, vld_l2, vld_n2;
  logic signed [C-1:0] c2_x, c2_y, c2_z, l2_x, l2_y, l2_z;
  logic signed [C-1:0] up_x, up_y, up_z;
  logic [3*C:0]        c2_side, l2_side;
  logic [3*C+1:0]      n2_side;
  logic [C-1:0]        len_2;
  logic                ok_2;

  assign ctl_c2 = '{en: en, vld: vld_n1};

  obf_cross #(.C(C), .F(F), .SW(3*C+1)) u_cross_up2 (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_c2),
    .a_x(n1_side[3*C:2*C+1]), .a_y(n1_side[2*C:C+1]), .a_z(n1_side[C:1]),
    .b_x(lf_x), .b_y(lf_y), .b_z(lf_z),
    .side_in({lf_x, lf_y, lf_z, n1_side[0]}),
    .out_vld(vld_c2), .o_x(c2_x), .o_y(c2_y), .o_z(c2_z), .side_out(c2_side)
  );

  assign ctl_l2 = '{en: en, vld: vld_c2};

  obf_len #(.C(C), .SW(3*C+1)) u_len_up2 (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_l2),
    .v_x(c2_x), .v_y(c2_y), .v_z(c2_z), .side_in(c2_side),
    .out_vld(vld_l2), .len(len_2), .o_x(l2_x), .o_y(l2_y), .o_z(l2_z),
    .side_out(l2_side)
  );

  assign ok_2   = (len_2 != '0) && (LW'(len_2) >= LW'(min_len_r));
  assign ctl_n2 = '{en: en, vld: vld_l2};

  obf_norm #(.C(C), .F(F), .SW(3*C+2)) u_norm_up (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_n2),
    .v_x(l2_x), .v_y(l2_y), .v_z(l2_z),
    .len(len_2), .ok(ok_2), .side_in({l2_side, !ok_2}),
    .out_vld(vld_n2), .o_x(up_x), .o_y(up_y), .o_z(up_z), .side_out(n2_side)
  );

  // result item
  assign out_valid         = vld_n2;
  assign out_left_x        = n2_side[3*C+1:2*C+2];
  assign out_left_y        = n2_side[2*C+1:C+2];
  assign out_left_z        = n2_side[C+1:2];
  assign out_used_fallback = n2_side[1];
  assign out_up_degenerate = n2_side[0];
  assign out_up_out_x      = up_x;
  assign out_up_out_y      = up_y;
  assign out_up_out_z      = up_z;

  // checks
  logic up_nonzero;
  assign up_nonzero = (out_up_out_x != '0) || (out_up_out_y != '0) || (out_up_out_z != '0);

  `OBF_ASSERT_NXT(a_skid_fill, !skid_vld_r && !(in_valid && !en), !skid_vld_r)
  `OBF_ASSERT_NXT(a_skid_drain, skid_vld_r && en, !skid_vld_r)
  `OBF_ASSERT_IMP(a_up_unit, out_valid && !out_up_degenerate, up_nonzero)

endmodule
`default_nettype wire

// ===== design/obf_cross.sv =====
// ----------------------------------------------------------------------------
// obf_cross
// Two-stage cross product a x b: products, then difference, round, saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module obf_cross
  import obf_pkg::*;
#(
  parameter int C  = 24,
  parameter int F  = 20,
  parameter int SW = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire obf_ctl_t            ctl,
  input  wire logic signed [C-1:0] a_x,
  input  wire logic signed [C-1:0] a_y,
  input  wire logic signed [C-1:0] a_z,
  input  wire logic signed [C-1:0] b_x,
  input  wire logic signed [C-1:0] b_y,
  input  wire logic signed [C-1:0] b_z,
  input  wire logic [SW-1:0]       side_in,
  output logic                     out_vld,
  output logic signed [C-1:0]      o_x,
  output logic signed [C-1:0]      o_y,
  output logic signed [C-1:0]      o_z,
  output logic [SW-1:0]            side_out
);

  localparam int DW = 2 * C + 2;
  localparam logic signed [DW-1:0] RND = DW'(1) << (F - 1);
  localparam logic signed [DW-1:0] HI  = {{(DW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [DW-1:0] LO  = ~HI;

  logic signed [2*C-1:0] p_r [0:5];
  logic                  vld1_r;
  logic [SW-1:0]         side1_r;
  logic signed [C-1:0]   x_r, y_r, z_r;
  logic                  vld2_r;
  logic [SW-1:0]         side2_r;

  // difference of products, round half up, saturate
  function automatic logic signed [C-1:0] rnd_sat(input logic signed [2*C-1:0] p,
                                                  input logic signed [2*C-1:0] q);
    logic signed [DW-1:0] t;
    t = DW'(p) - DW'(q) + RND;
    t = t >>> F;
    if (t > HI) begin
      rnd_sat = HI[C-1:0];
    end else if (t < LO) begin
      rnd_sat = LO[C-1:0];
    end else begin
      rnd_sat = t[C-1:0];
    end
  endfunction

  // stage 1: the six products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (ctl.en) begin
      vld1_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p_r[0]  <= a_y * b_z;
      p_r[1]  <= a_z * b_y;
      p_r[2]  <= a_z * b_x;
      p_r[3]  <= a_x * b_z;
      p_r[4]  <= a_x * b_y;
      p_r[5]  <= a_y * b_x;
      side1_r <= side_in;
    end
  end

  // stage 2: combine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (ctl.en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      x_r     <= rnd_sat(p_r[0], p_r[1]);
      y_r     <= rnd_sat(p_r[2], p_r[3]);
      z_r     <= rnd_sat(p_r[4], p_r[5]);
      side2_r <= side1_r;
    end
  end

  assign out_vld  = vld2_r;
  assign o_x      = x_r;
  assign o_y      = y_r;
  assign o_z      = z_r;
  assign side_out = side2_r;

endmodule
`default_nettype wire

// ===== design/obf_len.sv =====
// ----------------------------------------------------------------------------
// obf_len
// Vector length: squares, sum, then a pipelined integer square root
// retiring two root bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module obf_len
  import obf_pkg::*;
#(
  parameter int C  = 24,
  parameter int SW = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire obf_ctl_t            ctl,
  input  wire logic signed [C-1:0] v_x,
  input  wire logic signed [C-1:0] v_y,
  input  wire logic signed [C-1:0] v_z,
  input  wire logic [SW-1:0]       side_in,
  output logic                     out_vld,
  output logic [C-1:0]             len,
  output logic signed [C-1:0]      o_x,
  output logic signed [C-1:0]      o_y,
  output logic signed [C-1:0]      o_z,
  output logic [SW-1:0]            side_out
);

  localparam int SQ = (C + 1) / 2;  // root stages
  localparam int RW = C + 3;        // partial remainder width

  logic [2*C-1:0]      sq_r [0:2];
  logic signed [C-1:0] vec1_r [0:2];
  logic [SW-1:0]       side1_r;
  logic                vld1_r;

  logic [2*C-1:0]      n_q    [0:SQ-1];
  logic [RW-1:0]       rem_q  [0:SQ-1];
  logic [C-1:0]        root_q [0:SQ];
  logic signed [C-1:0] vec_q  [0:SQ][0:2];
  logic [SW-1:0]       side_q [0:SQ];
  logic                vld_q  [0:SQ];

  logic [C-1:0] mag [0:2];

  // stage 1: magnitudes squared
  always_comb begin
    mag[0] = v_x[C-1] ? (~v_x + 1'b1) : v_x;
    mag[1] = v_y[C-1] ? (~v_y + 1'b1) : v_y;
    mag[2] = v_z[C-1] ? (~v_z + 1'b1) : v_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (ctl.en) begin
      vld1_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= mag[i] * mag[i];
      end
      vec1_r[0] <= v_x;
      vec1_r[1] <= v_y;
      vec1_r[2] <= v_z;
      side1_r   <= side_in;
    end
  end

  // stage 2: sum of squares, seeds the root pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q[0] <= 1'b0;
    end else if (ctl.en) begin
      vld_q[0] <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      n_q[0]    <= sq_r[0] + sq_r[1] + sq_r[2];
      vec_q[0]  <= vec1_r;
      side_q[0] <= side1_r;
    end
  end

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  // root stages
  for (genvar s = 0; s < SQ; s++) begin : g_root
    logic [2*C-1:0] n_c;
    logic [RW-1:0]  rem_c;
    logic [RW-1:0]  trial;
    logic [C-1:0]   root_c;

    always_comb begin
      n_c    = n_q[s];
      rem_c  = rem_q[s];
      root_c = root_q[s];
      trial  = '0;
      for (int j = 0; j < 2; j++) begin
        if (s * 2 + j < C) begin
          rem_c = {rem_c[RW-3:0], n_c[2*C-1:2*C-2]};
          n_c   = n_c << 2;
          trial = RW'({root_c, 2'b01});
          if (rem_c >= trial) begin
            rem_c  = rem_c - trial;
            root_c = {root_c[C-2:0], 1'b1};
          end else begin
            root_c = {root_c[C-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_q[s+1] <= 1'b0;
      end else if (ctl.en) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        root_q[s+1] <= root_c;
        vec_q[s+1]  <= vec_q[s];
        side_q[s+1] <= side_q[s];
      end
    end

    if (s + 1 < SQ) begin : g_keep
      always_ff @(posedge clk) begin
        if (ctl.en) begin
          n_q[s+1]   <= n_c;
          rem_q[s+1] <= rem_c;
        end
      end
    end
  end

  assign out_vld  = vld_q[SQ];
  assign len      = root_q[SQ];
  assign o_x      = vec_q[SQ][0];
  assign o_y      = vec_q[SQ][1];
  assign o_z      = vec_q[SQ][2];
  assign side_out = side_q[SQ];

endmodule
`default_nettype wire

// ===== design/obf_norm.sv =====
// ----------------------------------------------------------------------------
// obf_norm
// Normalizes a vector by its length: three pipelined long dividers, two
// quotient bits per stage, then sign and saturation. Passes the vector
// unchanged when ok is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module obf_norm
  import obf_pkg::*;
#(
  parameter int C  = 24,
  parameter int F  = 20,
  parameter int SW = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire obf_ctl_t            ctl,
  input  wire logic signed [C-1:0] v_x,
  input  wire logic signed [C-1:0] v_y,
  input  wire logic signed [C-1:0] v_z,
  input  wire logic [C-1:0]        len,
  input  wire logic                ok,
  input  wire logic [SW-1:0]       side_in,
  output logic                     out_vld,
  output logic signed [C-1:0]      o_x,
  output logic signed [C-1:0]      o_y,
  output logic signed [C-1:0]      o_z,
  output logic [SW-1:0]            side_out
);

  localparam int D   = C + F;            // dividend width
  localparam int QW  = F + 1;            // quotient never exceeds 1.0
  localparam int DS  = (QW + 1) / 2;     // divider stages
  localparam int SW2 = ((F + 2 > C) ? F + 2 : C) + 1;
  localparam logic signed [SW2-1:0] HI = {{(SW2-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [SW2-1:0] LO = ~HI;

  logic [C-1:0]        rem_q  [0:DS-1][0:2];
  logic [QW-1:0]       bits_q [0:DS-1][0:2];
  logic [C-1:0]        len_q  [0:DS-1];
  logic [QW-1:0]       quo_q  [0:DS][0:2];
  logic signed [C-1:0] vec_q  [0:DS][0:2];
  logic                ok_q   [0:DS];
  logic [SW-1:0]       side_q [0:DS];
  logic                vld_q  [0:DS];

  logic [C-1:0] mag [0:2];
  logic [D-1:0] dvd [0:2];

  // entry: rounded dividend |v| * 1.0 + len / 2
  always_comb begin
    vec_q[0][0] = v_x;
    vec_q[0][1] = v_y;
    vec_q[0][2] = v_z;
    for (int i = 0; i < 3; i++) begin
      mag[i]       = vec_q[0][i][C-1] ? (~vec_q[0][i] + 1'b1) : vec_q[0][i];
      dvd[i]       = (D'(mag[i]) << F) + D'(len >> 1);
      rem_q[0][i]  = C'(dvd[i][D-1:QW]);
      bits_q[0][i] = dvd[i][QW-1:0];
      quo_q[0][i]  = '0;
    end
  end

  assign len_q[0]  = len;
  assign ok_q[0]   = ok;
  assign side_q[0] = side_in;
  assign vld_q[0]  = ctl.vld;

  // divider stages
  for (genvar s = 0; s < DS; s++) begin : g_div
    logic [C-1:0]  rem_c  [0:2];
    logic [QW-1:0] bits_c [0:2];
    logic [QW-1:0] quo_c  [0:2];
    logic [C:0]    r2     [0:2];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_c[i]  = rem_q[s][i];
        bits_c[i] = bits_q[s][i];
        quo_c[i]  = quo_q[s][i];
        r2[i]     = '0;
        for (int j = 0; j < 2; j++) begin
          if (s * 2 + j < QW) begin
            r2[i]     = {rem_c[i], bits_c[i][QW-1]};
            bits_c[i] = bits_c[i] << 1;
            if (r2[i] >= {1'b0, len_q[s]}) begin
              r2[i]    = r2[i] - {1'b0, len_q[s]};
              quo_c[i] = {quo_c[i][QW-2:0], 1'b1};
            end else begin
              quo_c[i] = {quo_c[i][QW-2:0], 1'b0};
            end
            rem_c[i] = r2[i][C-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_q[s+1] <= 1'b0;
      end else if (ctl.en) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        quo_q[s+1]  <= quo_c;
        vec_q[s+1]  <= vec_q[s];
        ok_q[s+1]   <= ok_q[s];
        side_q[s+1] <= side_q[s];
      end
    end

    if (s + 1 < DS) begin : g_keep
      always_ff @(posedge clk) begin
        if (ctl.en) begin
          rem_q[s+1]  <= rem_c;
          bits_q[s+1] <= bits_c;
          len_q[s+1]  <= len_q[s];
        end
      end
    end
  end

  // final stage: sign, saturate, pick normalized or raw
  logic signed [SW2-1:0] qs  [0:2];
  logic signed [C-1:0]   res [0:2];
  logic signed [C-1:0]   o_r [0:2];
  logic [SW-1:0]         side_r;
  logic                  vld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = SW2'(quo_q[DS][i]);
      if (vec_q[DS][i][C-1]) begin
        qs[i] = -qs[i];
      end
      if (!ok_q[DS]) begin
        res[i] = vec_q[DS][i];
      end else if (qs[i] > HI) begin
        res[i] = HI[C-1:0];
      end else if (qs[i] < LO) begin
        res[i] = LO[C-1:0];
      end else begin
        res[i] = qs[i][C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.en) begin
      vld_r <= vld_q[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      o_r    <= res;
      side_r <= side_q[DS];
    end
  end

  assign out_vld  = vld_r;
  assign o_x      = o_r[0];
  assign o_y      = o_r[1];
  assign o_z      = o_r[2];
  assign side_out = side_r;

endmodule
`default_nettype wire

// ===== sim/obf_basis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obf_basis_checker
// Watches the config port and both item channels, predicts each basis from
// its forward vector and the current registers, and compares field by field.
// ----------------------------------------------------------------------------
module obf_basis_checker
  import obf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [23:0]              cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [23:0]       in_fwd_x,
  input  logic signed [23:0]       in_fwd_y,
  input  logic signed [23:0]       in_fwd_z,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [23:0]       out_left_x,
  input  logic signed [23:0]       out_left_y,
  input  logic signed [23:0]       out_left_z,
  input  logic signed [23:0]       out_up_out_x,
  input  logic signed [23:0]       out_up_out_y,
  input  logic signed [23:0]       out_up_out_z,
  input  logic                     out_used_fallback,
  input  logic                     out_up_degenerate,
  output int                       fail_count,
  output int                       pending,
  output int                       basis_seen,
  output int                       fallback_seen,
  output int                       updeg_seen
);

  typedef logic signed [23:0] comp_t;
  typedef struct packed {
    comp_t lx, ly, lz, ux, uy, uz;
    logic  fb, dg;
  } basis_t;

  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;

  comp_t       up_ref [3];
  comp_t       fwd_ref [3];
  logic [20:0] min_len;
  basis_t      basis_q [$];

  function automatic longint clamp(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // round half up at the fraction point; >>> on longint floors
  function automatic longint round_frac(longint v);
    return (v + 64'sd524288) >>> 20;
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint o[3]);
    o[0] = clamp(round_frac(a[1] * b[2] - a[2] * b[1]));
    o[1] = clamp(round_frac(a[2] * b[0] - a[0] * b[2]));
    o[2] = clamp(round_frac(a[0] * b[1] - a[1] * b[0]));
  endfunction

  function automatic longint vec_len(input longint v[3]);
    longint unsigned s, r, b;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(v[i] * v[i]);
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic bit unit_scale(inout longint v[3], input longint len);
    longint q, m;
    if (len == 0 || len < longint'(min_len)) return 0;
    for (int i = 0; i < 3; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      q = ((m <<< 20) + (len >>> 1)) / len;
      v[i] = clamp(v[i] < 0 ? -q : q);
    end
    return 1;
  endfunction

  function automatic basis_t predict_basis(comp_t fx, comp_t fy, comp_t fz);
    longint f[3], ru[3], rf[3], lf[3], up[3], len;
    basis_t r;
    f = '{fx, fy, fz};
    for (int i = 0; i < 3; i++) begin
      ru[i] = up_ref[i];
      rf[i] = fwd_ref[i];
    end
    cross3(ru, f, lf);
    len = vec_len(lf);
    r.fb = len < longint'(min_len);
    if (r.fb) begin
      cross3(rf, f, lf);
      len = vec_len(lf);
    end
    void'(unit_scale(lf, len));
    cross3(f, lf, up);
    r.dg = !unit_scale(up, vec_len(up));
    r.lx = lf[0]; r.ly = lf[1]; r.lz = lf[2];
    r.ux = up[0]; r.uy = up[1]; r.uz = up[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    basis_seen = 0;
    fallback_seen = 0;
    updeg_seen = 0;
  end

  // register shadow, predictions on accept, checks on result
  always @(posedge clk) begin
    basis_t e;
    if (!rst_n) begin
      up_ref  = '{24'sd0, 24'sd0, 24'sd1048576};
      fwd_ref = '{24'sd1048576, 24'sd0, 24'sd0};
      min_len = 21'd105;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_UP_X:  up_ref[0]  = cfg_data;
          REG_UP_Y:  up_ref[1]  = cfg_data;
          REG_UP_Z:  up_ref[2]  = cfg_data;
          REG_FWD_X: fwd_ref[0] = cfg_data;
          REG_FWD_Y: fwd_ref[1] = cfg_data;
          REG_FWD_Z: fwd_ref[2] = cfg_data;
          REG_MIN:   min_len    = cfg_data[20:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        basis_q.push_back(predict_basis(in_fwd_x, in_fwd_y, in_fwd_z));
      if (out_valid && !out_stall) begin
        basis_seen++;
        if (basis_q.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          e = basis_q.pop_front();
          fallback_seen += e.fb;
          updeg_seen += e.dg;
          if (out_left_x != e.lx) report_mismatch("left_x", out_left_x, e.lx);
          if (out_left_y != e.ly) report_mismatch("left_y", out_left_y, e.ly);
          if (out_left_z != e.lz) report_mismatch("left_z", out_left_z, e.lz);
          if (out_up_out_x != e.ux) report_mismatch("up_x", out_up_out_x, e.ux);
          if (out_up_out_y != e.uy) report_mismatch("up_y", out_up_out_y, e.uy);
          if (out_up_out_z != e.uz) report_mismatch("up_z", out_up_out_z, e.uz);
          if (out_used_fallback != e.fb)
            report_mismatch("used_fallback", out_used_fallback, e.fb);
          if (out_up_degenerate != e.dg)
            report_mismatch("up_degenerate", out_up_degenerate, e.dg);
        end
      end
    end
    pending = basis_q.size();
  end

endmodule

// ===== sim/orthonormal_basis_from_forward_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthonormal_basis_from_forward_top_tb
// Drives forward vectors and register settings into the basis block with
// random idling on both sides; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_forward_top_tb;
  import obf_pkg::*;

  localparam int LATENCY = 57;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_fwd_x = '0, in_fwd_y = '0, in_fwd_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_left_x, out_left_y, out_left_z;
  logic signed [23:0] out_up_out_x, out_up_out_y, out_up_out_z;
  logic out_used_fallback, out_up_degenerate;
  int fail_count, pending, basis_seen, fallback_seen, updeg_seen;

  bit calm_phase = 0;   // no idling near the end
  bit hold_out = 0;     // long receiver hold-off request
  int fed = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  orthonormal_basis_from_forward_top dut (.*);

  obf_basis_checker chk (.*);

  // receiver stall: random bursts, or one long hold-off when requested
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
        hold_out = 0;
        @(posedge clk);
      end else if (!calm_phase && $urandom_range(3) == 0) begin
        n = $urandom_range(15, 1);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // offer one forward item, hold it until accepted
  task automatic send_fwd(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    if (!calm_phase && $urandom_range(7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_fwd_x <= x;
    in_fwd_y <= y;
    in_fwd_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fed++;
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random component: mostly moderate, sometimes full range, small or zero
  function automatic logic [23:0] rand_comp();
    case ($urandom_range(5))
      0:       return 24'($urandom);
      1:       return 24'(int'($urandom_range(400)) - 200);
      2:       return 24'(0);
      default: return 24'(int'($urandom_range(4194304)) - 2097152);
    endcase
  endfunction

  task automatic random_items(int n);
    logic [23:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      x = rand_comp();
      y = rand_comp();
      z = rand_comp();
      // some items parallel to a reference axis to hit fallback
      if ($urandom_range(9) == 0) begin
        x = 0;
        y = 0;
      end
      send_fwd(x, y, z);
    end
  endtask

  initial begin
    logic [23:0] ext [5];
    ext = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'h100000, 24'hFFFFFF};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero vector, along up axis, along fallback
    send_fwd(0, 0, 0);
    send_fwd(0, 0, 24'h100000);
    send_fwd(24'h100000, 0, 0);
    send_fwd(0, 0, 24'h7FFFFF);
    send_fwd(24'h100000, 0, 24'h100000);
    for (int i = 0; i < 5; i++)
      send_fwd(ext[i], ext[(i + 1) % 5], ext[(i + 3) % 5]);
    send_fwd(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_fwd(24'h800000, 24'h800000, 24'h800000);
    send_fwd(24'h000001, 24'h000001, 0);
    send_fwd(0, 24'h100000, 0);
    random_items(300);
    drain_idle();

    // zero threshold, extreme references
    write_reg(REG_MIN, 24'd0);
    write_reg(REG_UP_X, 24'h7FFFFF);
    write_reg(REG_UP_Y, 24'h800000);
    write_reg(REG_UP_Z, 24'h000000);
    write_reg(REG_FWD_X, 24'h800000);
    write_reg(REG_FWD_Y, 24'h7FFFFF);
    write_reg(REG_FWD_Z, 24'h7FFFFF);
    send_fwd(0, 0, 0);
    send_fwd(24'h7FFFFF, 24'h800000, 0);
    random_items(300);
    // long hold-off while still offering items
    hold_out = 1;
    random_items(200);
    drain_idle();

    // threshold of 1.0: mostly degenerate
    write_reg(REG_MIN, 24'h100000);
    write_reg(REG_UP_X, 24'h000000);
    write_reg(REG_UP_Y, 24'h000400);
    write_reg(REG_UP_Z, 24'h000000);
    write_reg(REG_FWD_X, 24'h000000);
    write_reg(REG_FWD_Y, 24'h000000);
    write_reg(REG_FWD_Z, 24'h000000);
    random_items(300);
    drain_idle();

    // random settings
    for (int p = 0; p < 3; p++) begin
      for (int r = 0; r < 6; r++) write_reg(r[CFG_IDX_W-1:0], rand_comp());
      write_reg(REG_MIN, 24'($urandom_range(1048576)));
      random_items(200);
      drain_idle();
    end

    // back to defaults, no idling
    write_reg(REG_UP_X, 0);
    write_reg(REG_UP_Y, 0);
    write_reg(REG_UP_Z, 24'h100000);
    write_reg(REG_FWD_X, 24'h100000);
    write_reg(REG_FWD_Y, 0);
    write_reg(REG_FWD_Z, 0);
    write_reg(REG_MIN, 24'd105);
    calm_phase = 1;
    random_items(150);
    drain_idle();

    $display("Sent %0d forward vectors over six register settings; %0d results checked,",
             fed, basis_seen);
    $display("%0d with fallback axis and %0d with degenerate up.",
             fallback_seen, updeg_seen);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
